FILE: src/mfpp_pkg.sv
// Shared types and constants for the mono framebuffer pixel packer.
// No dependencies; the address map and the top level refer to it by scoped names.
`default_nettype none

package mfpp_pkg;

  localparam int MAX_SIDE_DEF  = 400;
  localparam int FB_BYTES_DEF  = 15000;
  localparam int OUT_DEPTH_DEF = 4;

  localparam int SIDE_W   = 9;
  localparam int COLOR_W  = 16;
  localparam int INDEX_W  = 14;
  localparam int BYTE_W   = 8;
  localparam int STORE_AW = 17;
  localparam int CMP_W    = STORE_AW + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [COLOR_W-1:0] WHITE_THRESHOLD = 16'h7FFF;
  localparam logic [BYTE_W-1:0]  WHITE_BYTE      = 8'hFF;
  localparam logic [BYTE_W-1:0]  TOP_BIT_MASK    = 8'h80;

  localparam logic [CFG_IDX_W-1:0] CFG_LANDSCAPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic              landscape_mode;
    logic [SIDE_W-1:0] panel_width;
    logic [SIDE_W-1:0] panel_height;
  } cfg_t;

  typedef struct packed {
    logic                is_write;
    logic                is_read;
    logic                hit;
    logic [STORE_AW-1:0] addr;
    logic [BYTE_W-1:0]   mask;
    logic                bit_val;
  } pix_op_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

endpackage

`default_nettype wire

FILE: src/mfpp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// A read and a write to the same address in one cycle return the old data.
`default_nettype none

module mfpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/mfpp_addr_map.sv
// Maps one request to a store address, bit mask and pixel bit, with range checks.
// Depends on mfpp_pkg for the configuration and operation structs.
`default_nettype none

module mfpp_addr_map #(
  parameter int MAX_SIDE = mfpp_pkg::MAX_SIDE_DEF,
  parameter int FB_BYTES = mfpp_pkg::FB_BYTES_DEF
) (
  input  mfpp_pkg::cfg_t                      cfg,
  input  wire                                 req_type,
  input  wire [mfpp_pkg::SIDE_W-1:0]          pixel_x,
  input  wire [mfpp_pkg::SIDE_W-1:0]          pixel_y,
  input  wire [mfpp_pkg::COLOR_W-1:0]         pixel_color,
  input  wire [mfpp_pkg::INDEX_W-1:0]         byte_index,
  output mfpp_pkg::pix_op_t                   op
);

  localparam int CW = mfpp_pkg::CMP_W;

  logic [mfpp_pkg::SIDE_W-1:0] w;
  logic [mfpp_pkg::SIDE_W-1:0] h;
  logic [mfpp_pkg::SIDE_W-1:0] v;
  logic                        in_panel;
  logic [7:0]                  mul_a;
  logic [6:0]                  mul_b;
  logic [6:0]                  mul_c;
  logic [14:0]                 prod;
  logic [15:0]                 lin;
  logic [2:0]                  sel;
  logic [CW-1:0]               wr_addr;
  logic [CW-1:0]               rd_addr;
  logic                        is_write;

  // Panel sizes saturate at the largest supported side.
  assign w = ({2'b00, cfg.panel_width} > 11'(MAX_SIDE)) ?
             mfpp_pkg::SIDE_W'(MAX_SIDE) : cfg.panel_width;
  assign h = ({2'b00, cfg.panel_height} > 11'(MAX_SIDE)) ?
             mfpp_pkg::SIDE_W'(MAX_SIDE) : cfg.panel_height;

  assign in_panel = (pixel_x < w) && (pixel_y < h);

  // Landscape rows are counted from the bottom edge.
  assign v = h - mfpp_pkg::SIDE_W'(1) - pixel_y;

  assign mul_a = cfg.landscape_mode ? pixel_x[8:1] : pixel_y[8:1];
  assign mul_b = cfg.landscape_mode ? h[8:2] : w[8:2];
  assign mul_c = cfg.landscape_mode ? v[8:2] : pixel_x[8:2];

  assign prod = {7'd0, mul_a} * {8'd0, mul_b};
  assign lin  = {1'b0, prod} + {9'd0, mul_c};

  assign sel = cfg.landscape_mode ? {v[1:0], pixel_x[0]} : {pixel_x[1:0], pixel_y[0]};

  assign wr_addr  = {{(CW-16){1'b0}}, lin};
  assign rd_addr  = {{(CW-mfpp_pkg::INDEX_W){1'b0}}, byte_index};
  assign is_write = (req_type == mfpp_pkg::REQ_WRITE);

  always_comb begin
    op.is_write = is_write;
    op.is_read  = !is_write;
    op.mask     = mfpp_pkg::TOP_BIT_MASK >> sel;
    op.bit_val  = (pixel_color >= mfpp_pkg::WHITE_THRESHOLD);
    if (is_write) begin
      op.hit  = in_panel && (wr_addr < CW'(FB_BYTES));
      op.addr = wr_addr[mfpp_pkg::STORE_AW-1:0];
    end else begin
      op.hit  = (rd_addr < CW'(FB_BYTES));
      op.addr = rd_addr[mfpp_pkg::STORE_AW-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: src/mfpp_out_fifo.sv
// Small register FIFO that holds read results until the downstream side takes them.
// Depends on nothing but its parameters; it reports its fill level for flow control.
`default_nettype none

module mfpp_out_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          push,
  input  wire [WIDTH-1:0]              push_data,
  output logic                         tvalid,
  input  wire                          tready,
  output logic [WIDTH-1:0]             tdata,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             pop;

  assign tvalid = (count != '0);
  assign tdata  = entries[rd_ptr];
  assign pop    = tvalid && tready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/mono_framebuffer_pixel_packer_unit.sv
// Top level of the mono framebuffer pixel packer: request pipeline, frame store, output queue.
// Depends on mfpp_pkg, mfpp_ram, mfpp_addr_map and mfpp_out_fifo.
// Throughput is one request per cycle while s_tready is high (low during the clearing pass or while every
// output queue slot is reserved); the single store port pair and forwarding of the previous write set that
// figure. Reads go via s1 and s2 to the output queue. After reset a clearing pass writes white to every
// byte while no request is taken; configuration writes are accepted throughout and registers reset at once.
`default_nettype none

module mono_framebuffer_pixel_packer_unit #(
  parameter int MAX_SIDE  = mfpp_pkg::MAX_SIDE_DEF,
  parameter int FB_BYTES  = mfpp_pkg::FB_BYTES_DEF,
  parameter int OUT_DEPTH = mfpp_pkg::OUT_DEPTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // pixel_x[8:0], pixel_y[17:9], pixel_color[33:18], byte_index[47:34]
  input  wire [47:0]                        s_tdata,
  // req_type[0]
  input  wire [0:0]                         s_tuser,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // read_data[7:0]
  output logic [mfpp_pkg::BYTE_W-1:0]       m_tdata,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [mfpp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [mfpp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ADDR_W = $clog2(FB_BYTES);
  localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
  localparam int BW     = mfpp_pkg::BYTE_W;

  mfpp_pkg::cfg_t    cfg;
  mfpp_pkg::state_t  state;
  logic [ADDR_W-1:0] clr_addr;

  logic                            s1_valid;
  logic                            s1_type;
  logic [mfpp_pkg::SIDE_W-1:0]     s1_x;
  logic [mfpp_pkg::SIDE_W-1:0]     s1_y;
  logic [mfpp_pkg::COLOR_W-1:0]    s1_color;
  logic [mfpp_pkg::INDEX_W-1:0]    s1_index;
  mfpp_pkg::pix_op_t               s1_op;

  logic                            s2_valid;
  mfpp_pkg::pix_op_t               s2_op;

  logic                            fwd_valid;
  logic [ADDR_W-1:0]               fwd_addr;
  logic [BW-1:0]                   fwd_data;

  logic [BW-1:0]                   ram_rdata;
  logic [BW-1:0]                   cur_byte;
  logic [BW-1:0]                   new_byte;
  logic                            item_we;
  logic                            ram_we;
  logic [ADDR_W-1:0]               ram_waddr;
  logic [BW-1:0]                   ram_wdata;

  logic                            out_push;
  logic [BW-1:0]                   out_data;
  logic [CNT_W-1:0]                out_count;
  logic [CNT_W:0]                  pending;
  logic                            in_accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.landscape_mode <= 1'b1;
      cfg.panel_width    <= mfpp_pkg::SIDE_W'(400);
      cfg.panel_height   <= mfpp_pkg::SIDE_W'(300);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mfpp_pkg::CFG_LANDSCAPE: cfg.landscape_mode <= cfg_data[0];
        mfpp_pkg::CFG_WIDTH:     cfg.panel_width    <= cfg_data;
        mfpp_pkg::CFG_HEIGHT:    cfg.panel_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Reads still in the pipeline have a reserved slot in the output queue.
  assign pending = {1'b0, out_count}
                 + (CNT_W+1)'(s1_valid && (s1_type == mfpp_pkg::REQ_READ))
                 + (CNT_W+1)'(s2_valid && s2_op.is_read);
  assign s_tready  = (state == mfpp_pkg::ST_RUN) && (pending < (CNT_W+1)'(OUT_DEPTH));
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mfpp_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        mfpp_pkg::ST_CLEAR: begin
          if (clr_addr == ADDR_W'(FB_BYTES - 1)) begin
            state <= mfpp_pkg::ST_RUN;
          end else begin
            clr_addr <= clr_addr + ADDR_W'(1);
          end
        end
        mfpp_pkg::ST_RUN: begin
          state <= mfpp_pkg::ST_RUN;
        end
        default: state <= mfpp_pkg::ST_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_type  <= s_tuser[0];
      s1_x     <= s_tdata[8:0];
      s1_y     <= s_tdata[17:9];
      s1_color <= s_tdata[33:18];
      s1_index <= s_tdata[47:34];
    end
  end

  mfpp_addr_map #(
    .MAX_SIDE (MAX_SIDE),
    .FB_BYTES (FB_BYTES)
  ) u_addr_map (
    .cfg         (cfg),
    .req_type    (s1_type),
    .pixel_x     (s1_x),
    .pixel_y     (s1_y),
    .pixel_color (s1_color),
    .byte_index  (s1_index),
    .op          (s1_op)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_op <= s1_op;
  end

  // The store returns old data when the previous write hits the same byte.
  assign cur_byte = (fwd_valid && (fwd_addr == s2_op.addr[ADDR_W-1:0])) ? fwd_data : ram_rdata;
  assign new_byte = s2_op.bit_val ? (cur_byte | s2_op.mask) : (cur_byte & ~s2_op.mask);
  assign item_we  = s2_valid && s2_op.is_write && s2_op.hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= item_we;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= s2_op.addr[ADDR_W-1:0];
    fwd_data <= new_byte;
  end

  assign ram_we    = (state == mfpp_pkg::ST_CLEAR) || item_we;
  assign ram_waddr = (state == mfpp_pkg::ST_CLEAR) ? clr_addr : s2_op.addr[ADDR_W-1:0];
  assign ram_wdata = (state == mfpp_pkg::ST_CLEAR) ? mfpp_pkg::WHITE_BYTE : new_byte;

  mfpp_ram #(
    .WIDTH (BW),
    .DEPTH (FB_BYTES)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (s1_op.addr[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign out_push = s2_valid && s2_op.is_read;
  assign out_data = s2_op.hit ? cur_byte : '0;

  mfpp_out_fifo #(
    .WIDTH (BW),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push),
    .push_data (out_data),
    .tvalid    (m_tvalid),
    .tready    (m_tready),
    .tdata     (m_tdata),
    .count     (out_count)
  );

  a_no_request_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == mfpp_pkg::ST_CLEAR) |-> (!in_accept && !s1_valid && !s2_valid))
    else $error("request in flight during the clearing pass");

  a_queue_has_room: assert property (@(posedge clk) disable iff (rst)
    out_push |-> ((out_count < CNT_W'(OUT_DEPTH)) || (m_tvalid && m_tready)))
    else $error("read result pushed into a full output queue");

  a_clear_covers_store: assert property (@(posedge clk) disable iff (rst)
    $rose(state == mfpp_pkg::ST_RUN) |-> ($past(clr_addr) == ADDR_W'(FB_BYTES - 1)))
    else $error("clearing pass ended before the last byte");

  a_forward_follows_write: assert property (@(posedge clk) disable iff (rst)
    item_we |=> (fwd_valid && (fwd_data == $past(new_byte))))
    else $error("forwarding register missed the last store write");

endmodule

`default_nettype wire
